[rtl/gpi_pkg.sv]
// gpi_pkg: shared types, codes, coefficients and saturation helpers for the pefrl integrator
`default_nettype none
package gpi_pkg;

  localparam int NUM_BODIES_DEF = 2;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 31;
  localparam int NUM_PHASES = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAV_CONST = 1'b1;

  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_STEP = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;

  // integrator coefficients, signed q2.30
  localparam logic signed [31:0] C_ZETA   = 32'sd191789505;
  localparam logic signed [31:0] C_LAMBDA = -32'sd228000305;
  localparam logic signed [31:0] C_CHI    = -32'sd71151054;
  localparam logic signed [31:0] C_K1     = 32'sd764871217;
  localparam logic signed [31:0] C_K2     = 32'sd832464922;

  typedef logic [2:0][31:0] vec3_t;

  typedef struct packed {
    vec3_t       pos;
    vec3_t       vel;
    logic [30:0] mass;
  } body_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [5:0]  body_index;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] vel_x;
    logic [31:0] vel_y;
    logic [31:0] vel_z;
    logic [30:0] body_mass;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  out_index;
    logic [31:0] out_pos_x;
    logic [31:0] out_pos_y;
    logic [31:0] out_pos_z;
    logic [31:0] out_vel_x;
    logic [31:0] out_vel_y;
    logic [31:0] out_vel_z;
    logic        saturated;
  } out_item_t;

  typedef struct packed {
    logic        start;
    logic        sqrt_mode;
    logic [63:0] num;
    logic [31:0] den;
  } dsu_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] res;
  } dsu_rsp_t;

  typedef struct packed {
    logic        ovf;
    logic [31:0] val;
  } sat32_t;

  typedef struct packed {
    logic        ovf;
    logic [30:0] val;
  } satu31_t;

  // drift on even phases, kick on odd phases
  function automatic logic signed [31:0] coef(input logic [3:0] ph);
    logic signed [31:0] c;
    unique case (ph)
      4'd0, 4'd8: c = C_ZETA;
      4'd1, 4'd7: c = C_K1;
      4'd2, 4'd6: c = C_CHI;
      4'd3, 4'd5: c = C_LAMBDA;
      4'd4:       c = C_K2;
      default:    c = '0;
    endcase
    return c;
  endfunction

  function automatic sat32_t sat_add(input logic [31:0] a, input logic [31:0] b,
                                     input logic sub);
    logic [32:0] s;
    sat32_t      r;
    s = sub ? ({a[31], a} - {b[31], b}) : ({a[31], a} + {b[31], b});
    r.ovf = s[32] ^ s[31];
    r.val = r.ovf ? (s[32] ? 32'h8000_0000 : 32'h7fff_ffff) : s[31:0];
    return r;
  endfunction

  function automatic sat32_t sat_s66(input logic [65:0] v);
    sat32_t r;
    r.ovf = !((&v[65:31]) || !(|v[65:31]));
    r.val = r.ovf ? (v[65] ? 32'h8000_0000 : 32'h7fff_ffff) : v[31:0];
    return r;
  endfunction

  function automatic satu31_t sat_u66(input logic [65:0] v);
    satu31_t r;
    r.ovf = |v[65:31];
    r.val = r.ovf ? 31'h7fff_ffff : v[30:0];
    return r;
  endfunction

  function automatic satu31_t sat_u64(input logic [63:0] v);
    satu31_t r;
    r.ovf = |v[63:31];
    r.val = r.ovf ? 31'h7fff_ffff : v[30:0];
    return r;
  endfunction

  // signed quotient from magnitude and sign
  function automatic sat32_t sat_quo(input logic [63:0] q, input logic neg);
    sat32_t r;
    if (neg) begin
      r.ovf = (|q[63:32]) || (q[31] && (|q[30:0]));
      r.val = r.ovf ? 32'h8000_0000 : (32'h0 - q[31:0]);
    end else begin
      r.ovf = |q[63:31];
      r.val = r.ovf ? 32'h7fff_ffff : q[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/gpi_mul.sv]
// gpi_mul: shared signed 33x33 multiplier with registered product
`default_nettype none
module gpi_mul (
  input  wire logic               clk,
  input  wire logic signed [32:0] a,
  input  wire logic signed [32:0] b,
  output logic signed [65:0]      prod
);

  logic signed [65:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end

  assign prod = prod_r;

endmodule
`default_nettype wire

[rtl/gpi_divsqrt.sv]
// gpi_divsqrt: shared bit-serial unit for unsigned divide and integer square root
`default_nettype none
module gpi_divsqrt (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire gpi_pkg::dsu_req_t req,
  output gpi_pkg::dsu_rsp_t    rsp
);

  localparam logic [5:0] DIV_LAST  = 6'd63;
  localparam logic [5:0] SQRT_LAST = 6'd31;

  logic        busy_r;
  logic        mode_r;
  logic        done_r;
  logic [5:0]  cnt_r;
  logic [63:0] acc_r;
  logic [63:0] aux_r;
  logic [63:0] res_r;
  logic [31:0] den_r;

  logic [32:0] div_tr;
  logic [63:0] cmp_a;
  logic [63:0] cmp_b;
  logic [64:0] diff;
  logic        ge;

  // divide: acc holds the remainder, aux shifts the dividend out
  // root: acc holds the residue, aux holds the trial bit
  always_comb begin
    div_tr = {acc_r[31:0], aux_r[63]};
    cmp_a  = mode_r ? acc_r : {31'b0, div_tr};
    cmp_b  = mode_r ? (res_r + aux_r) : {32'b0, den_r};
    diff   = {1'b0, cmp_a} - {1'b0, cmp_b};
    ge     = ~diff[64];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.sqrt_mode ? SQRT_LAST : DIV_LAST;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      mode_r <= req.sqrt_mode;
      den_r  <= req.den;
      res_r  <= '0;
      if (req.sqrt_mode) begin
        acc_r <= req.num;
        aux_r <= 64'h4000_0000_0000_0000;
      end else begin
        acc_r <= '0;
        aux_r <= req.num;
      end
    end else if (busy_r) begin
      if (mode_r) begin
        acc_r <= ge ? diff[63:0] : acc_r;
        res_r <= ge ? ((res_r >> 1) + aux_r) : (res_r >> 1);
        aux_r <= aux_r >> 2;
      end else begin
        acc_r <= ge ? diff[63:0] : cmp_a;
        res_r <= {res_r[62:0], ge};
        aux_r <= aux_r << 1;
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.res  = res_r;

endmodule
`default_nettype wire

[rtl/gravity_pefrl_integrator.sv]
// gravity_pefrl_integrator: n-body gravity with a pefrl step, sequencer and body storage
//
//   channel | signals                         | beat
//   in      | in_valid in_ready in_data       | one load, step or read request
//   out     | out_valid out_ready out_data    | one body read back, with sticky flag
//   cfg     | cfg_we cfg_index cfg_data       | one register write, no wait
//
// a load is written to storage when accepted; a read waits for the output register.
// a step runs the phases in turn and waits on each divide and root
// of the shared bit-serial unit.
// reset clears all body and force storage at once through valid bits.
// in_ready is low while a step or read runs; a waiting result does not block loads.
`default_nettype none
module gravity_pefrl_integrator #(
  parameter int NUM_BODIES = gpi_pkg::NUM_BODIES_DEF,
  parameter int FRAC_BITS  = gpi_pkg::FRAC_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire gpi_pkg::in_item_t               in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output gpi_pkg::out_item_t                   out_data,
  input  wire logic                            cfg_we,
  input  wire logic [gpi_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [gpi_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int IW = $clog2(NUM_BODIES);
  localparam logic [30:0] ONE_Q = 31'(1) << FRAC_BITS;
  localparam int NS = 37;

  typedef enum logic [NS-1:0] {
    S_IDLE    = 37'b1 << 0,
    S_RD      = 37'b1 << 1,
    S_PH      = 37'b1 << 2,
    S_PH_H    = 37'b1 << 3,
    S_DR_RD   = 37'b1 << 4,
    S_DR_LD   = 37'b1 << 5,
    S_DR_MUL  = 37'b1 << 6,
    S_DR_ACC  = 37'b1 << 7,
    S_DR_WR   = 37'b1 << 8,
    S_PR_RA   = 37'b1 << 9,
    S_PR_LA   = 37'b1 << 10,
    S_PR_LB   = 37'b1 << 11,
    S_PR_D    = 37'b1 << 12,
    S_PR_DSQ  = 37'b1 << 13,
    S_PR_Z    = 37'b1 << 14,
    S_PR_SQ   = 37'b1 << 15,
    S_PR_GM0  = 37'b1 << 16,
    S_PR_GM1  = 37'b1 << 17,
    S_PR_GMM0 = 37'b1 << 18,
    S_PR_GMM1 = 37'b1 << 19,
    S_PR_Q0   = 37'b1 << 20,
    S_PR_Q1   = 37'b1 << 21,
    S_PR_F0   = 37'b1 << 22,
    S_PR_F1   = 37'b1 << 23,
    S_PR_C0   = 37'b1 << 24,
    S_PR_C1   = 37'b1 << 25,
    S_PR_C2   = 37'b1 << 26,
    S_PR_WA   = 37'b1 << 27,
    S_PR_WB   = 37'b1 << 28,
    S_PR_NEXT = 37'b1 << 29,
    S_KK_RD   = 37'b1 << 30,
    S_KK_LD   = 37'b1 << 31,
    S_KK_M0   = 37'b1 << 32,
    S_KK_M1   = 37'b1 << 33,
    S_KK_M2   = 37'b1 << 34,
    S_KK_WR   = 37'b1 << 35,
    S_PH_END  = 37'b1 << 36
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [30:0] dt_r;
  logic [30:0] g_r;

  // sequencer counters
  logic [3:0]    ph_r;
  logic [IW-1:0] i_r;
  logic [IW-1:0] j_r;
  logic [1:0]    k_r;

  // working registers
  logic signed [31:0] h_r;
  logic signed [31:0] pa_r [3];
  logic signed [31:0] va_r [3];
  logic signed [31:0] fa_r [3];
  logic signed [31:0] pb_r [3];
  logic signed [31:0] fb_r [3];
  logic signed [31:0] d_r  [3];
  logic [30:0]        ma_r;
  logic [30:0]        mb_r;
  logic [63:0]        d2_r;
  logic [31:0]        r_r;
  logic [30:0]        s_r;
  logic               neg_r;
  logic               sat_r;

  // read request bookkeeping
  logic [5:0] rd_idx_r;
  logic       rd_ok_r;

  // output register
  logic               out_valid_r;
  gpi_pkg::out_item_t out_data_r;

  // storage
  gpi_pkg::body_t bmem [NUM_BODIES];
  gpi_pkg::vec3_t fmem [NUM_BODIES];
  logic [NUM_BODIES-1:0] bvalid_r;
  logic [NUM_BODIES-1:0] fvalid_r;
  gpi_pkg::body_t brd_r;
  gpi_pkg::vec3_t frd_r;
  logic           brd_v_r;
  logic           frd_v_r;

  logic           b_we;
  logic [IW-1:0]  b_waddr;
  gpi_pkg::body_t b_wdata;
  logic [IW-1:0]  b_raddr;
  logic           f_we;
  logic [IW-1:0]  f_waddr;
  gpi_pkg::vec3_t f_wdata;
  logic [IW-1:0]  f_raddr;
  gpi_pkg::body_t bcur;
  gpi_pkg::vec3_t fcur;

  // shared units
  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] prod;
  gpi_pkg::dsu_req_t  dreq;
  gpi_pkg::dsu_rsp_t  drsp;

  logic               in_acc;
  logic               in_range;
  logic               out_load;
  logic               sat_hit;
  logic [65:0]        prod_neg;
  logic [63:0]        prod_abs;
  gpi_pkg::sat32_t    dx_sat;
  gpi_pkg::sat32_t    padd_sat;
  gpi_pkg::sat32_t    d_sat;
  gpi_pkg::satu31_t   gm_sat;
  gpi_pkg::satu31_t   dq_sat;
  gpi_pkg::sat32_t    quo_sat;
  gpi_pkg::sat32_t    fa_sat;
  gpi_pkg::sat32_t    fb_sat;
  gpi_pkg::sat32_t    va_sat;

  gpi_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  gpi_divsqrt u_dsu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign in_range  = (32'(in_data.body_index) < 32'(NUM_BODIES));
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_load  = (state_r == S_RD) && (!out_valid_r || out_ready);

  // unwritten entries read as the reset body and a zero force
  always_comb begin
    bcur = brd_v_r ? brd_r : '{pos: '0, vel: '0, mass: ONE_Q};
    fcur = frd_v_r ? frd_r : '0;
  end

  always_comb begin
    prod_neg = 66'(-prod);
    prod_abs = prod[65] ? prod_neg[63:0] : prod[63:0];
    dx_sat   = gpi_pkg::sat_s66(66'(prod >>> FRAC_BITS));
    padd_sat = gpi_pkg::sat_add(pa_r[k_r], dx_sat.val, 1'b0);
    d_sat    = gpi_pkg::sat_add(pb_r[k_r], pa_r[k_r], 1'b1);
    gm_sat   = gpi_pkg::sat_u66(66'(prod >>> FRAC_BITS));
    dq_sat   = gpi_pkg::sat_u64(drsp.res);
    quo_sat  = gpi_pkg::sat_quo(drsp.res, neg_r);
    fa_sat   = gpi_pkg::sat_add(fa_r[k_r], quo_sat.val, 1'b0);
    fb_sat   = gpi_pkg::sat_add(fb_r[k_r], quo_sat.val, 1'b1);
    va_sat   = gpi_pkg::sat_add(va_r[k_r], quo_sat.val, 1'b0);
  end

  // multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_PH: begin
        mul_a = {2'b0, dt_r};
        mul_b = {gpi_pkg::coef(ph_r)[31], gpi_pkg::coef(ph_r)};
      end
      S_DR_MUL: begin
        mul_a = {va_r[k_r][31], va_r[k_r]};
        mul_b = {h_r[31], h_r};
      end
      S_PR_D: begin
        mul_a = {d_sat.val[31], d_sat.val};
        mul_b = {d_sat.val[31], d_sat.val};
      end
      S_PR_GM0: begin
        mul_a = {2'b0, g_r};
        mul_b = {2'b0, ma_r};
      end
      S_PR_GMM0: begin
        mul_a = {2'b0, s_r};
        mul_b = {2'b0, mb_r};
      end
      S_PR_C0: begin
        mul_a = {2'b0, s_r};
        mul_b = {d_r[k_r][31], d_r[k_r]};
      end
      S_KK_M0: begin
        mul_a = {fa_r[k_r][31], fa_r[k_r]};
        mul_b = {h_r[31], h_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // divide / root launches
  always_comb begin
    dreq.start     = 1'b0;
    dreq.sqrt_mode = 1'b0;
    dreq.num       = '0;
    dreq.den       = r_r;
    unique case (state_r)
      S_PR_Z: begin
        dreq.start     = (d2_r != 64'd0);
        dreq.sqrt_mode = 1'b1;
        dreq.num       = d2_r;
      end
      S_PR_Q0, S_PR_F0: begin
        dreq.start = 1'b1;
        dreq.num   = {33'b0, s_r} << FRAC_BITS;
      end
      S_PR_C1: begin
        dreq.start = 1'b1;
        dreq.num   = prod_abs;
      end
      S_KK_M1: begin
        dreq.start = 1'b1;
        dreq.num   = prod_abs;
        dreq.den   = {1'b0, ma_r};
      end
      default: begin
        dreq.start = 1'b0;
      end
    endcase
  end

  // storage ports
  always_comb begin
    b_we    = 1'b0;
    b_waddr = i_r;
    b_wdata.pos  = {pa_r[2], pa_r[1], pa_r[0]};
    b_wdata.vel  = {va_r[2], va_r[1], va_r[0]};
    b_wdata.mass = ma_r;
    if (state_r == S_IDLE) begin
      b_we         = in_acc && (in_data.req_type == gpi_pkg::REQ_LOAD) && in_range;
      b_waddr      = in_data.body_index[IW-1:0];
      b_wdata.pos  = {in_data.pos_z, in_data.pos_y, in_data.pos_x};
      b_wdata.vel  = {in_data.vel_z, in_data.vel_y, in_data.vel_x};
      b_wdata.mass = in_data.body_mass;
    end else if ((state_r == S_DR_WR) || (state_r == S_KK_WR)) begin
      b_we = 1'b1;
    end

    priority if (state_r == S_IDLE) begin
      b_raddr = in_data.body_index[IW-1:0];
    end else if (state_r == S_RD) begin
      b_raddr = rd_idx_r[IW-1:0];
    end else if (state_r == S_PR_LA) begin
      b_raddr = j_r;
    end else begin
      b_raddr = i_r;
    end
    f_raddr = (state_r == S_PR_LA) ? j_r : i_r;

    f_we    = (state_r == S_PR_WA) || (state_r == S_PR_WB);
    f_waddr = (state_r == S_PR_WB) ? j_r : i_r;
    f_wdata = (state_r == S_PR_WB) ? {fb_r[2], fb_r[1], fb_r[0]}
                                   : {fa_r[2], fa_r[1], fa_r[0]};
  end

  always_ff @(posedge clk) begin
    if (b_we) begin
      bmem[b_waddr] <= b_wdata;
    end
    brd_r <= bmem[b_raddr];
    if (f_we) begin
      fmem[f_waddr] <= f_wdata;
    end
    frd_r <= fmem[f_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bvalid_r <= '0;
      fvalid_r <= '0;
      brd_v_r  <= 1'b0;
      frd_v_r  <= 1'b0;
    end else begin
      brd_v_r <= bvalid_r[b_raddr];
      frd_v_r <= fvalid_r[f_raddr];
      if (b_we) begin
        bvalid_r[b_waddr] <= 1'b1;
      end
      // a force pass starts from zero forces
      if ((state_r == S_PH_H) && ph_r[0]) begin
        fvalid_r <= '0;
      end else if (f_we) begin
        fvalid_r[f_waddr] <= 1'b1;
      end
    end
  end

  // saturation events of the current cycle
  always_comb begin
    unique case (state_r)
      S_DR_ACC:             sat_hit = dx_sat.ovf || padd_sat.ovf;
      S_PR_D:               sat_hit = d_sat.ovf;
      S_PR_GM1, S_PR_GMM1:  sat_hit = gm_sat.ovf;
      S_PR_Q1, S_PR_F1:     sat_hit = drsp.done && dq_sat.ovf;
      S_PR_C2:              sat_hit = drsp.done && (quo_sat.ovf || fa_sat.ovf || fb_sat.ovf);
      S_KK_M2:              sat_hit = drsp.done && (quo_sat.ovf || va_sat.ovf);
      default:              sat_hit = 1'b0;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (in_data.req_type == gpi_pkg::REQ_STEP)) begin
          state_nxt = S_PH;
        end else if (in_acc && (in_data.req_type == gpi_pkg::REQ_READ)) begin
          state_nxt = S_RD;
        end
      end
      S_RD:      state_nxt = out_load ? S_IDLE : S_RD;
      S_PH:      state_nxt = S_PH_H;
      S_PH_H:    state_nxt = ph_r[0] ? S_PR_RA : S_DR_RD;
      S_DR_RD:   state_nxt = S_DR_LD;
      S_DR_LD:   state_nxt = S_DR_MUL;
      S_DR_MUL:  state_nxt = S_DR_ACC;
      S_DR_ACC:  state_nxt = (k_r == 2'd2) ? S_DR_WR : S_DR_MUL;
      S_DR_WR:   state_nxt = (i_r == IW'(NUM_BODIES - 1)) ? S_PH_END : S_DR_RD;
      S_PR_RA:   state_nxt = S_PR_LA;
      S_PR_LA:   state_nxt = S_PR_LB;
      S_PR_LB:   state_nxt = S_PR_D;
      S_PR_D:    state_nxt = S_PR_DSQ;
      S_PR_DSQ:  state_nxt = (k_r == 2'd2) ? S_PR_Z : S_PR_D;
      S_PR_Z:    state_nxt = (d2_r == 64'd0) ? S_PR_NEXT : S_PR_SQ;
      S_PR_SQ:   state_nxt = drsp.done ? S_PR_GM0 : S_PR_SQ;
      S_PR_GM0:  state_nxt = S_PR_GM1;
      S_PR_GM1:  state_nxt = S_PR_GMM0;
      S_PR_GMM0: state_nxt = S_PR_GMM1;
      S_PR_GMM1: state_nxt = S_PR_Q0;
      S_PR_Q0:   state_nxt = S_PR_Q1;
      S_PR_Q1:   state_nxt = drsp.done ? S_PR_F0 : S_PR_Q1;
      S_PR_F0:   state_nxt = S_PR_F1;
      S_PR_F1:   state_nxt = drsp.done ? S_PR_C0 : S_PR_F1;
      S_PR_C0:   state_nxt = S_PR_C1;
      S_PR_C1:   state_nxt = S_PR_C2;
      S_PR_C2: begin
        if (drsp.done) begin
          state_nxt = (k_r == 2'd2) ? S_PR_WA : S_PR_C0;
        end
      end
      S_PR_WA:   state_nxt = S_PR_WB;
      S_PR_WB:   state_nxt = S_PR_NEXT;
      S_PR_NEXT: begin
        if ((j_r == IW'(NUM_BODIES - 1)) && (i_r == IW'(NUM_BODIES - 2))) begin
          state_nxt = S_KK_RD;
        end else begin
          state_nxt = S_PR_RA;
        end
      end
      S_KK_RD:   state_nxt = S_KK_LD;
      S_KK_LD:   state_nxt = (bcur.mass == 31'd0) ? S_KK_WR : S_KK_M0;
      S_KK_M0:   state_nxt = S_KK_M1;
      S_KK_M1:   state_nxt = S_KK_M2;
      S_KK_M2: begin
        if (drsp.done) begin
          state_nxt = (k_r == 2'd2) ? S_KK_WR : S_KK_M0;
        end
      end
      S_KK_WR:   state_nxt = (i_r == IW'(NUM_BODIES - 1)) ? S_PH_END : S_KK_RD;
      S_PH_END:  state_nxt = (ph_r == 4'(gpi_pkg::NUM_PHASES - 1)) ? S_IDLE : S_PH;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dt_r        <= ONE_Q;
      g_r         <= ONE_Q;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sat_r   <= sat_r | sat_hit;
      if (cfg_we && (cfg_index == gpi_pkg::CFG_TIME_STEP)) begin
        dt_r <= cfg_data;
      end
      if (cfg_we && (cfg_index == gpi_pkg::CFG_GRAV_CONST)) begin
        g_r <= cfg_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.out_index <= rd_idx_r;
      out_data_r.out_pos_x <= rd_ok_r ? bcur.pos[0] : 32'd0;
      out_data_r.out_pos_y <= rd_ok_r ? bcur.pos[1] : 32'd0;
      out_data_r.out_pos_z <= rd_ok_r ? bcur.pos[2] : 32'd0;
      out_data_r.out_vel_x <= rd_ok_r ? bcur.vel[0] : 32'd0;
      out_data_r.out_vel_y <= rd_ok_r ? bcur.vel[1] : 32'd0;
      out_data_r.out_vel_z <= rd_ok_r ? bcur.vel[2] : 32'd0;
      out_data_r.saturated <= sat_r;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        rd_idx_r <= in_data.body_index;
        rd_ok_r  <= in_range;
        ph_r     <= 4'd0;
      end
      S_PH_H: begin
        h_r <= prod[61:30];
        i_r <= '0;
        j_r <= IW'(1);
      end
      S_DR_LD: begin
        for (int n = 0; n < 3; n++) begin
          pa_r[n] <= bcur.pos[n];
          va_r[n] <= bcur.vel[n];
        end
        ma_r <= bcur.mass;
        k_r  <= 2'd0;
      end
      S_DR_ACC: begin
        pa_r[k_r] <= padd_sat.val;
        k_r       <= k_r + 2'd1;
      end
      S_DR_WR, S_KK_WR: begin
        i_r <= i_r + IW'(1);
      end
      S_PR_LA: begin
        for (int n = 0; n < 3; n++) begin
          pa_r[n] <= bcur.pos[n];
          fa_r[n] <= fcur[n];
        end
        ma_r <= bcur.mass;
      end
      S_PR_LB: begin
        for (int n = 0; n < 3; n++) begin
          pb_r[n] <= bcur.pos[n];
          fb_r[n] <= fcur[n];
        end
        mb_r <= bcur.mass;
        d2_r <= '0;
        k_r  <= 2'd0;
      end
      S_PR_D: begin
        d_r[k_r] <= d_sat.val;
      end
      S_PR_DSQ: begin
        d2_r <= d2_r + prod[63:0];
        k_r  <= k_r + 2'd1;
      end
      S_PR_SQ: begin
        r_r <= drsp.res[31:0];
      end
      S_PR_GM1, S_PR_GMM1: begin
        s_r <= gm_sat.val;
      end
      S_PR_Q1: begin
        if (drsp.done) begin
          s_r <= dq_sat.val;
        end
      end
      S_PR_F1: begin
        if (drsp.done) begin
          s_r <= dq_sat.val;
        end
        k_r <= 2'd0;
      end
      S_PR_C1, S_KK_M1: begin
        neg_r <= prod[65];
      end
      S_PR_C2: begin
        if (drsp.done) begin
          fa_r[k_r] <= fa_sat.val;
          fb_r[k_r] <= fb_sat.val;
          k_r       <= k_r + 2'd1;
        end
      end
      S_PR_NEXT: begin
        if (j_r == IW'(NUM_BODIES - 1)) begin
          if (i_r == IW'(NUM_BODIES - 2)) begin
            i_r <= '0;
          end else begin
            i_r <= i_r + IW'(1);
            j_r <= i_r + IW'(2);
          end
        end else begin
          j_r <= j_r + IW'(1);
        end
      end
      S_KK_LD: begin
        for (int n = 0; n < 3; n++) begin
          pa_r[n] <= bcur.pos[n];
          va_r[n] <= bcur.vel[n];
          fa_r[n] <= fcur[n];
        end
        ma_r <= bcur.mass;
        k_r  <= 2'd0;
      end
      S_KK_M2: begin
        if (drsp.done) begin
          va_r[k_r] <= va_sat.val;
          k_r       <= k_r + 2'd1;
        end
      end
      S_PH_END: begin
        ph_r <= ph_r + 4'd1;
      end
      default: begin
        ph_r <= ph_r;
      end
    endcase
  end

endmodule
`default_nettype wire
